FILE: sv/vacps_pkg.sv
// Shared types and constants for the view-axis closest point search.
// No dependencies; every other file of the block but vacps_checker imports this package.
package vacps_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int INDEX_BITS_DEF = 16;
    localparam int DIR_BITS       = 8;
    localparam int CFG_ADDR_W     = 5;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [2:0] {
        REG_POS_X,
        REG_POS_Y,
        REG_POS_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_PROD,
        ST_SQUARE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic prod;
        logic square;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic compare;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_full;
    } dp_stat_t;

endpackage

FILE: sv/vacps_cfg.sv
// Configuration register file with an APB-style access port.
// Depends on vacps_pkg for register indexes and port widths.
module vacps_cfg import vacps_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,
    output logic signed [COORD_BITS-1:0] pos_x,
    output logic signed [COORD_BITS-1:0] pos_y,
    output logic signed [COORD_BITS-1:0] pos_z,
    output logic signed [DIR_BITS-1:0]   dir_x,
    output logic signed [DIR_BITS-1:0]   dir_y,
    output logic signed [DIR_BITS-1:0]   dir_z
);

    logic signed [COORD_BITS-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [DIR_BITS-1:0]   dir_x_reg, dir_y_reg, dir_z_reg;
    logic                         wr_en;
    reg_idx_t                     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= '1;
        end else if (wr_en) begin
            case (idx)
                REG_POS_X: pos_x_reg <= pwdata[COORD_BITS-1:0];
                REG_POS_Y: pos_y_reg <= pwdata[COORD_BITS-1:0];
                REG_POS_Z: pos_z_reg <= pwdata[COORD_BITS-1:0];
                REG_DIR_X: dir_x_reg <= pwdata[DIR_BITS-1:0];
                REG_DIR_Y: dir_y_reg <= pwdata[DIR_BITS-1:0];
                REG_DIR_Z: dir_z_reg <= pwdata[DIR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_POS_X: prdata = CFG_DATA_W'($unsigned(pos_x_reg));
            REG_POS_Y: prdata = CFG_DATA_W'($unsigned(pos_y_reg));
            REG_POS_Z: prdata = CFG_DATA_W'($unsigned(pos_z_reg));
            REG_DIR_X: prdata = CFG_DATA_W'($unsigned(dir_x_reg));
            REG_DIR_Y: prdata = CFG_DATA_W'($unsigned(dir_y_reg));
            REG_DIR_Z: prdata = CFG_DATA_W'($unsigned(dir_z_reg));
            default:   prdata = '0;
        endcase
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;
    assign dir_x = dir_x_reg;
    assign dir_y = dir_y_reg;
    assign dir_z = dir_z_reg;

endmodule

FILE: sv/vacps_ctrl.sv
// Sequencer that walks one input word through the datapath steps.
// Depends on vacps_pkg for the state, command and status types.
module vacps_ctrl import vacps_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = stat.last ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                // Wait until the output register is free or being drained.
                if (!stat.out_full || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: sv/vacps_dp.sv
// Datapath: offsets, dot product, squared length, the exact cross-multiplied
// compare against the running best, and the result register. Uses vacps_pkg.
module vacps_dp import vacps_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_cmd_t                      cmd,
    output dp_stat_t                     stat,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic [INDEX_BITS-1:0]        point_index,
    input  logic                         last_point,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic signed [DIR_BITS-1:0]   dir_x,
    input  logic signed [DIR_BITS-1:0]   dir_y,
    input  logic signed [DIR_BITS-1:0]   dir_z,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [INDEX_BITS-1:0]        best_index,
    output logic                         found
);

    localparam int D_W    = COORD_BITS + 1;
    localparam int DV_W   = D_W + DIR_BITS;
    localparam int DOT_W  = DV_W + 2;
    localparam int DOTU_W = DOT_W - 1;
    localparam int LEN_W  = 2 * D_W;
    localparam int SQ_W   = 2 * DOTU_W;
    localparam int HALF_W = DOTU_W;
    localparam int PART_W = HALF_W + LEN_W;
    localparam int CMP_W  = SQ_W + LEN_W;

    logic signed [COORD_BITS-1:0] pt_reg [3];
    logic [INDEX_BITS-1:0]        idx_reg;
    logic                         last_reg;
    logic signed [D_W-1:0]        d_reg [3];
    logic signed [DOT_W-1:0]      dot_reg;
    logic [LEN_W-1:0]             len_reg;
    logic [SQ_W-1:0]              dn_sq_reg, bd_sq_reg;
    logic [PART_W-1:0]            lhs_lo_reg, rhs_lo_reg, lhs_hi_reg, rhs_hi_reg;
    logic [CMP_W-1:0]             lhs_reg, rhs_reg;
    logic [DOTU_W-1:0]            best_dot_reg;
    logic [LEN_W-1:0]             best_len_reg;
    logic [INDEX_BITS-1:0]        best_point_reg;
    logic                         have_best_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0]        out_index_reg;
    logic                         out_found_reg;

    logic signed [COORD_BITS-1:0] pos [3];
    logic signed [DIR_BITS-1:0]   dir [3];
    logic signed [D_W-1:0]        d_next [3];
    logic signed [DV_W-1:0]       dv [3];
    logic signed [LEN_W-1:0]      dd [3];
    logic signed [DOT_W-1:0]      dot_next;
    logic [LEN_W-1:0]             len_next;
    logic [DOTU_W-1:0]            dn;
    logic [HALF_W-1:0]            mul_a_l, mul_a_r;
    logic [PART_W-1:0]            prod_l, prod_r;
    logic                         qualify, take;

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next[i] = D_W'(pt_reg[i]) - D_W'(pos[i]);
            dv[i]     = d_reg[i] * dir[i];
            dd[i]     = d_reg[i] * d_reg[i];
        end
        dot_next = DOT_W'(dv[0]) + DOT_W'(dv[1]) + DOT_W'(dv[2]);
        len_next = $unsigned(dd[0]) + $unsigned(dd[1]) + $unsigned(dd[2]);
    end

    assign qualify = !dot_reg[DOT_W-1] && (dot_reg != '0);
    assign dn      = dot_reg[DOTU_W-1:0];

    // The 2*DOTU_W-bit squares are multiplied by the lengths in two halves
    // through the same pair of multipliers.
    assign mul_a_l = cmd.mul_hi ? dn_sq_reg[SQ_W-1:HALF_W] : dn_sq_reg[HALF_W-1:0];
    assign mul_a_r = cmd.mul_hi ? bd_sq_reg[SQ_W-1:HALF_W] : bd_sq_reg[HALF_W-1:0];
    assign prod_l  = mul_a_l * best_len_reg;
    assign prod_r  = mul_a_r * len_reg;

    // Equality keeps the older point, so the first one wins a tie.
    assign take = qualify && (!have_best_reg || (lhs_reg > rhs_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pt_reg[0] <= point_x;
            pt_reg[1] <= point_y;
            pt_reg[2] <= point_z;
            idx_reg   <= point_index;
            last_reg  <= last_point;
        end
        if (cmd.diff) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= d_next[i];
            end
        end
        if (cmd.prod) begin
            dot_reg <= dot_next;
            len_reg <= len_next;
        end
        if (cmd.square) begin
            dn_sq_reg <= dn * dn;
            bd_sq_reg <= best_dot_reg * best_dot_reg;
        end
        if (cmd.mul_lo) begin
            lhs_lo_reg <= prod_l;
            rhs_lo_reg <= prod_r;
        end
        if (cmd.mul_hi) begin
            lhs_hi_reg <= prod_l;
            rhs_hi_reg <= prod_r;
        end
        if (cmd.sum) begin
            lhs_reg <= (CMP_W'(lhs_hi_reg) << HALF_W) + CMP_W'(lhs_lo_reg);
            rhs_reg <= (CMP_W'(rhs_hi_reg) << HALF_W) + CMP_W'(rhs_lo_reg);
        end
        if (cmd.out_load) begin
            out_index_reg <= have_best_reg ? best_point_reg : '0;
            out_found_reg <= have_best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            best_dot_reg   <= '0;
            best_len_reg   <= '0;
            best_point_reg <= '0;
            have_best_reg  <= 1'b0;
        end else if (cmd.compare && take) begin
            best_dot_reg   <= dn;
            best_len_reg   <= len_reg;
            best_point_reg <= idx_reg;
            have_best_reg  <= 1'b1;
        end
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.last     = last_reg;
    assign stat.out_full = out_valid_reg;
    assign m_valid       = out_valid_reg;
    assign best_index    = out_index_reg;
    assign found         = out_found_reg;

endmodule

FILE: sv/view_axis_closest_point_search.sv
// Top level of the view-axis closest point search; instantiates vacps_cfg,
// vacps_ctrl and vacps_dp, and uses vacps_pkg.
//
// Candidate points stream in one word at a time; the block keeps the point
// in front of the viewpoint whose direction makes the smallest angle with the
// view direction, and on the word flagged by tlast gives one result word with
// the winning index in tdata and the found flag in tuser (index 0 when nothing
// qualified). Each input word holds tready low after acceptance while the
// sequencer steps through offset, products, squaring, two passes over the
// shared pair of square-by-length multipliers, the wide sum and the compare;
// a last word adds the output state, which loads the result register once
// any earlier result no longer waits on m_axis_tready.
// The user must write registers over the APB port only while no set is in
// progress; the block itself does not enforce this.
module view_axis_closest_point_search import vacps_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int S_TDATA_W = ((3 * COORD_BITS + INDEX_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((INDEX_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // point_x, point_y, point_z, point_index (from bit 0 up), zero padded
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // best_index, zero padded
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // found
    output logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_z;
    logic signed [DIR_BITS-1:0]   dir_x, dir_y, dir_z;
    logic [INDEX_BITS-1:0]        best_index;
    dp_cmd_t                      cmd;
    dp_stat_t                     stat;

    vacps_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .pos_z   (pos_z),
        .dir_x   (dir_x),
        .dir_y   (dir_y),
        .dir_z   (dir_z)
    );

    vacps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vacps_dp #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .point_x     (s_axis_tdata[COORD_BITS-1:0]),
        .point_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .point_z     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .point_index (s_axis_tdata[3*COORD_BITS+INDEX_BITS-1:3*COORD_BITS]),
        .last_point  (s_axis_tlast),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .m_ready     (m_axis_tready),
        .m_valid     (m_axis_tvalid),
        .best_index  (best_index),
        .found       (m_axis_tuser)
    );

    assign m_axis_tdata = M_TDATA_W'(best_index);

endmodule

FILE: sv/vacps_checker.sv
// Port-level checks for the view-axis closest point search, bound to the
// top level. Sees only the top level's ports; no package needed.
module vacps_checker #(
    parameter int INDEX_BITS = 16,
    localparam int M_TDATA_W = ((INDEX_BITS + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // A set with nothing in front reports index zero.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("index nonzero with found low");

    // An accepted word keeps the input closed for the following cycles.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened while a word is being evaluated");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind view_axis_closest_point_search vacps_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_vacps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
